@@ hdl/lmcs_pkg.sv @@
// Types, codes and constants shared by the lift motion command sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lmcs_pkg;

    localparam int MarginWidth = 15;
    localparam logic [1:0] DECEL_CYCLES = 2'd3;

    localparam logic [15:0] AFTER_SCAN_POSITION = 16'hfff6;

    localparam logic [7:0] CMD_INIT       = 8'hbf;
    localparam logic [7:0] CMD_STOP       = 8'hfc;
    localparam logic [7:0] CMD_PRE_MOVE   = 8'hc4;
    localparam logic [7:0] CMD_UP         = 8'h86;
    localparam logic [7:0] CMD_DOWN       = 8'h85;
    localparam logic [7:0] CMD_DECEL      = 8'h87;
    localparam logic [7:0] CMD_PRE_STOP   = 8'h84;
    localparam logic [7:0] CMD_DOWN_ERROR = 8'hbd;
    localparam logic [7:0] CMD_UP_ERROR   = 8'hbc;

    localparam logic [1:0] REQ_KEEP = 2'd0;
    localparam logic [1:0] REQ_STOP = 2'd1;
    localparam logic [1:0] REQ_UP   = 2'd2;
    localparam logic [1:0] REQ_DOWN = 2'd3;

    typedef enum logic [2:0] {
        ST_AFTER_SCAN = 3'd0,
        ST_STOP       = 3'd1,
        ST_PRE_MOVE   = 3'd2,
        ST_UP         = 3'd3,
        ST_DOWN       = 3'd4,
        ST_UP_DECEL   = 3'd5,
        ST_DOWN_DECEL = 3'd6,
        ST_PRE_STOP   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        TGT_STOP = 2'd0,
        TGT_UP   = 2'd1,
        TGT_DOWN = 2'd2
    } target_t;

    typedef struct packed {
        logic signed [15:0] encoder_a;
        logic signed [15:0] encoder_b;
        logic [1:0]         target_request;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] command_position;
        logic [7:0]         command_code;
        logic [2:0]         motion_state;
    } out_item_t;

    typedef struct packed {
        mode_t       mode;
        target_t     target;
        logic [1:0]  decel_count;
        logic [15:0] decel_position;
    } seq_state_t;

endpackage
`default_nettype wire

@@ hdl/lift_motion_command_sequencer_top.sv @@
// Top level of the lift motion command sequencer: state, margin and result registers.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in       | in_valid/in_ready  | in_data  (encoder_a, encoder_b, target_request)
//  out      | out_valid/out_ready| out_data (command_position, command_code, motion_state)
//  cfg      | cfg_valid/cfg_ready| cfg_data (decel_margin)
//
// One transaction per clock unless out_ready stalls; the result is registered on accept.
// Throughput is set by the single result register, refilled whenever it drains.
// in_ready drops only while a result is held and out_ready is low.
// rst_n clears the motion state to after-scan, target to stop, margin to zero.
`timescale 1ns / 1ps
`default_nettype none
module lift_motion_command_sequencer_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire lmcs_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output lmcs_pkg::out_item_t                    out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lmcs_pkg::MarginWidth-1:0]  cfg_data
);

    lmcs_pkg::seq_state_t                state_reg;
    lmcs_pkg::seq_state_t                state_next;
    lmcs_pkg::out_item_t                 frame;
    lmcs_pkg::out_item_t                 out_data_reg;
    logic                                out_valid_reg;
    logic [lmcs_pkg::MarginWidth-1:0]    margin_reg;
    logic                                in_accept;

    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_accept = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    lmcs_step u_step (
        .cur    (state_reg),
        .item   (in_data),
        .margin (margin_reg),
        .frame  (frame),
        .nxt    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= lmcs_pkg::ST_AFTER_SCAN;
            state_reg.target         <= lmcs_pkg::TGT_STOP;
            state_reg.decel_count    <= 2'd0;
            state_reg.decel_position <= 16'd0;
            out_valid_reg            <= 1'b0;
            margin_reg               <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                margin_reg <= cfg_data;
            end
            if (in_accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= frame;
        end
    end

endmodule
`default_nettype wire

@@ hdl/lmcs_step.sv @@
// Command frame and next motion state for one transaction.
`timescale 1ns / 1ps
`default_nettype none
module lmcs_step (
    input  wire lmcs_pkg::seq_state_t           cur,
    input  wire lmcs_pkg::in_item_t             item,
    input  wire logic [lmcs_pkg::MarginWidth-1:0] margin,
    output lmcs_pkg::out_item_t                 frame,
    output lmcs_pkg::seq_state_t                nxt
);

    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic               err;
    logic [15:0]        up_target;
    logic [15:0]        down_target;
    logic [15:0]        decel_pos;
    lmcs_pkg::target_t  target_new;
    logic [1:0]         count_inc;

    always_comb
    begin
        lo          = (item.encoder_a < item.encoder_b) ? item.encoder_a : item.encoder_b;
        hi          = (item.encoder_a > item.encoder_b) ? item.encoder_a : item.encoder_b;
        err         = item.encoder_a[15] | item.encoder_b[15];
        up_target   = 16'(hi) + {1'b0, margin};
        down_target = 16'(lo) - {1'b0, margin};
        count_inc   = cur.decel_count + 2'd1;

        decel_pos = cur.decel_position;
        if (cur.decel_count == 2'd0)
        begin
            if (cur.mode == lmcs_pkg::ST_UP_DECEL)
            begin
                decel_pos = up_target;
            end
            else if (cur.mode == lmcs_pkg::ST_DOWN_DECEL)
            begin
                decel_pos = down_target;
            end
        end

        frame.motion_state = cur.mode;
        unique case (cur.mode)
            lmcs_pkg::ST_AFTER_SCAN:
            begin
                frame.command_position = lmcs_pkg::AFTER_SCAN_POSITION;
                frame.command_code     = lmcs_pkg::CMD_INIT;
            end
            lmcs_pkg::ST_STOP:
            begin
                frame.command_position = hi;
                frame.command_code     = lmcs_pkg::CMD_STOP;
            end
            lmcs_pkg::ST_PRE_MOVE:
            begin
                frame.command_position = hi;
                frame.command_code     = lmcs_pkg::CMD_PRE_MOVE;
            end
            lmcs_pkg::ST_UP:
            begin
                frame.command_position = err ? hi : lo;
                frame.command_code     = err ? lmcs_pkg::CMD_UP_ERROR : lmcs_pkg::CMD_UP;
            end
            lmcs_pkg::ST_DOWN:
            begin
                frame.command_position = err ? 16'sd0 : hi;
                frame.command_code     = err ? lmcs_pkg::CMD_DOWN_ERROR : lmcs_pkg::CMD_DOWN;
            end
            lmcs_pkg::ST_UP_DECEL, lmcs_pkg::ST_DOWN_DECEL:
            begin
                frame.command_position = decel_pos;
                frame.command_code     = lmcs_pkg::CMD_DECEL;
            end
            default:
            begin
                frame.command_position = hi;
                frame.command_code     = lmcs_pkg::CMD_PRE_STOP;
            end
        endcase

        unique case (item.target_request)
            lmcs_pkg::REQ_STOP: target_new = lmcs_pkg::TGT_STOP;
            lmcs_pkg::REQ_UP:   target_new = lmcs_pkg::TGT_UP;
            lmcs_pkg::REQ_DOWN: target_new = lmcs_pkg::TGT_DOWN;
            default:            target_new = cur.target;
        endcase

        nxt                = cur;
        nxt.target         = target_new;
        nxt.decel_position = decel_pos;
        unique case (cur.mode)
            lmcs_pkg::ST_AFTER_SCAN:
            begin
                nxt.mode = lmcs_pkg::ST_STOP;
            end
            lmcs_pkg::ST_STOP:
            begin
                if (target_new != lmcs_pkg::TGT_STOP)
                begin
                    nxt.mode = lmcs_pkg::ST_PRE_MOVE;
                end
            end
            lmcs_pkg::ST_PRE_MOVE:
            begin
                if (target_new == lmcs_pkg::TGT_UP)
                begin
                    nxt.mode = lmcs_pkg::ST_UP;
                end
                else if (target_new == lmcs_pkg::TGT_DOWN)
                begin
                    nxt.mode = lmcs_pkg::ST_DOWN;
                end
            end
            lmcs_pkg::ST_UP:
            begin
                if (target_new != lmcs_pkg::TGT_UP)
                begin
                    nxt.mode        = lmcs_pkg::ST_UP_DECEL;
                    nxt.decel_count = 2'd0;
                end
            end
            lmcs_pkg::ST_DOWN:
            begin
                if (target_new != lmcs_pkg::TGT_DOWN)
                begin
                    nxt.mode        = lmcs_pkg::ST_DOWN_DECEL;
                    nxt.decel_count = 2'd0;
                end
            end
            lmcs_pkg::ST_UP_DECEL, lmcs_pkg::ST_DOWN_DECEL:
            begin
                nxt.decel_count = count_inc;
                if (count_inc >= lmcs_pkg::DECEL_CYCLES)
                begin
                    nxt.mode = lmcs_pkg::ST_PRE_STOP;
                end
            end
            default:
            begin
                nxt.mode = lmcs_pkg::ST_STOP;
            end
        endcase
    end

endmodule
`default_nettype wire
